### hw/rtl/ffrs_pkg.sv
// ffrs_pkg: types and codes for the feeder fault-removal sequencer.
// No dependencies; used by the channel instances and by the top level.
`timescale 1ns / 1ps

package ffrs_pkg;

  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 8;

  typedef logic [LIMIT_W-1:0]     limit_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // register indexes on the configuration port
  localparam cfg_index_t REG_GATHER_LIMIT      = cfg_index_t'(0);
  localparam cfg_index_t REG_OPEN_CHECK_LIMIT  = cfg_index_t'(1);
  localparam cfg_index_t REG_BACKUP_WAIT_LIMIT = cfg_index_t'(2);
  localparam cfg_index_t REG_REJECT_WAIT_LIMIT = cfg_index_t'(3);

  localparam limit_t GATHER_LIMIT_RST      = limit_t'(50);
  localparam limit_t OPEN_CHECK_LIMIT_RST  = limit_t'(200);
  localparam limit_t BACKUP_WAIT_LIMIT_RST = limit_t'(300);
  localparam limit_t REJECT_WAIT_LIMIT_RST = limit_t'(200);

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_GATHER   = 3'd1,
    PH_DELAY    = 3'd2,
    PH_TREAT    = 3'd3,
    PH_CENTER   = 3'd4,
    PH_BACKUP   = 3'd5,
    PH_BKDETECT = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    HO_NONE     = 3'd0,
    HO_INSULATE = 3'd1,
    HO_TRANSFER = 3'd2,
    HO_DISTLOCK = 3'd3,
    HO_PROTLOCK = 3'd4,
    HO_EXIT     = 3'd5
  } hand_off_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_BACKUP = 2'd1,
    ST_INIT   = 2'd2,
    ST_AREA   = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_SUCCESS = 2'd1,
    OUT_FAILURE = 2'd2
  } outcome_t;

  typedef struct packed {
    logic restart;
    logic fault_seen;
    logic trigger_seen;
    logic reject_insulate;
    logic transfer_permitted;
    logic income_loss_fault;
    logic in_fault_area;
    logic on_tie_path;
    logic open_permitted;
    logic open_position;
    logic backup_cleared;
    logic neighbour_refused;
  } in_item_t;

  typedef struct packed {
    phase_t    phase_now;
    logic      running;
    logic      open_command;
    logic      send_status;
    logic      send_removal;
    outcome_t  removal_outcome;
    logic      refused_open;
    logic      snapshot_request;
    hand_off_t exit_target;
    step_t     insulate_step;
  } out_item_t;

  typedef struct packed {
    cfg_index_t index;
    limit_t     data;
  } cfg_item_t;

endpackage

### hw/rtl/ffrs_chan_if.sv
// ffrs_chan_if: valid/ready channel carrying one payload item.
// Payload type is set per instance; no package dependency.
`timescale 1ns / 1ps

interface ffrs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/feeder_fault_removal_sequencer_top.sv
// feeder_fault_removal_sequencer_top: protection sequencer for one line switch.
// Depends on ffrs_pkg and ffrs_chan_if.
//
//   channel | dir | payload      | accepted when
//   in_ch   | in  | in_item_t    | in_ch.valid && in_ch.ready
//   out_ch  | out | out_item_t   | out_ch.valid && out_ch.ready
//   cfg_ch  | in  | cfg_item_t   | cfg_ch.valid && cfg_ch.ready (always ready)
//
// One item per cycle while out_ch is not stalled: the phase/timer update is one level
// of logic from the state registers into the result register.
// in_ch.ready drops only while a result sits unread and out_ch.ready is low.
// Synchronous active-low reset clears state and restores register defaults.
`timescale 1ns / 1ps

module feeder_fault_removal_sequencer_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ffrs_chan_if.sink   in_ch,
  ffrs_chan_if.source out_ch,
  ffrs_chan_if.sink   cfg_ch
);
  import ffrs_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  limit_t    gather_limit_r, open_check_limit_r, backup_wait_limit_r, reject_wait_limit_r;
  phase_t    phase_r, phase_nxt;
  logic      sub_step_r, sub_step_nxt;
  timer_t    elapsed_r, elapsed_nxt;
  limit_t    active_limit_r, active_limit_nxt;
  logic      first_send_r, first_send_nxt;
  logic      run_flag_r, run_flag_nxt;
  hand_off_t hand_off_r, hand_off_nxt;
  step_t     hand_off_step_r, hand_off_step_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  in_item_t  it;
  logic      in_acc;
  logic      over;
  logic      open_cmd, st_msg, rm_msg, rej, snap;
  outcome_t  outcome;

  assign it           = in_ch.payload;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_limit_r      <= GATHER_LIMIT_RST;
      open_check_limit_r  <= OPEN_CHECK_LIMIT_RST;
      backup_wait_limit_r <= BACKUP_WAIT_LIMIT_RST;
      reject_wait_limit_r <= REJECT_WAIT_LIMIT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.payload.index)
        REG_GATHER_LIMIT:      gather_limit_r      <= cfg_ch.payload.data;
        REG_OPEN_CHECK_LIMIT:  open_check_limit_r  <= cfg_ch.payload.data;
        REG_BACKUP_WAIT_LIMIT: backup_wait_limit_r <= cfg_ch.payload.data;
        REG_REJECT_WAIT_LIMIT: reject_wait_limit_r <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

  // next state and result for one tick
  always_comb begin
    phase_nxt         = phase_r;
    sub_step_nxt      = sub_step_r;
    active_limit_nxt  = active_limit_r;
    first_send_nxt    = first_send_r;
    run_flag_nxt      = run_flag_r;
    hand_off_nxt      = hand_off_r;
    hand_off_step_nxt = hand_off_step_r;
    open_cmd = 1'b0;
    st_msg   = 1'b0;
    rm_msg   = 1'b0;
    rej      = 1'b0;
    snap     = 1'b0;
    outcome  = OUT_NONE;

    // timer counts first, saturating
    elapsed_nxt = (elapsed_r == '1) ? elapsed_r : elapsed_r + timer_t'(1);
    over = CMP_W'(elapsed_nxt) >= CMP_W'(active_limit_r);

    case (phase_r)
      PH_START: begin
        if (it.fault_seen) begin
          run_flag_nxt = 1'b1; st_msg = 1'b1; snap = 1'b1;
          active_limit_nxt = gather_limit_r; elapsed_nxt = '0;
          sub_step_nxt = 1'b0; phase_nxt = PH_GATHER;
        end else if (it.trigger_seen) begin
          run_flag_nxt = 1'b1; st_msg = 1'b1;
          active_limit_nxt = gather_limit_r; elapsed_nxt = '0;
          first_send_nxt = 1'b1; sub_step_nxt = 1'b0; phase_nxt = PH_DELAY;
        end else if (it.reject_insulate || (!it.transfer_permitted && it.income_loss_fault)) begin
          run_flag_nxt = 1'b1;
          hand_off_nxt = HO_INSULATE; hand_off_step_nxt = ST_BACKUP; phase_nxt = PH_DONE;
        end else if (it.transfer_permitted) begin
          run_flag_nxt = 1'b1; sub_step_nxt = 1'b0;
          hand_off_nxt = HO_TRANSFER; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
        end
      end
      PH_GATHER: begin
        if (over) phase_nxt = PH_TREAT;
      end
      PH_DELAY: begin
        if (!sub_step_r) begin
          if (over) begin
            if (it.fault_seen) phase_nxt = PH_TREAT;
            else sub_step_nxt = 1'b1;
          end else if (it.fault_seen && first_send_r) begin
            first_send_nxt = 1'b0; st_msg = 1'b1;
          end
        end else begin
          phase_nxt = PH_DONE;
          if (it.in_fault_area && it.on_tie_path) begin
            hand_off_nxt = HO_INSULATE; hand_off_step_nxt = ST_INIT;
          end else if (it.on_tie_path) begin
            hand_off_nxt = HO_INSULATE; hand_off_step_nxt = ST_AREA;
          end else begin
            hand_off_nxt = HO_EXIT; hand_off_step_nxt = ST_NONE;
          end
        end
      end
      PH_TREAT: begin
        if (it.in_fault_area) begin
          if (it.open_permitted) begin
            open_cmd = 1'b1;
            active_limit_nxt = open_check_limit_r; elapsed_nxt = '0;
            sub_step_nxt = 1'b0; phase_nxt = PH_CENTER;
          end
        end else begin
          active_limit_nxt = backup_wait_limit_r; elapsed_nxt = '0;
          phase_nxt = PH_BACKUP;
        end
      end
      PH_CENTER: begin
        if (!sub_step_r) begin
          if (over) begin
            rej = 1'b1; st_msg = 1'b1; sub_step_nxt = 1'b1;
            active_limit_nxt = reject_wait_limit_r; elapsed_nxt = '0;
          end else if (!it.fault_seen && it.open_position) begin
            outcome = OUT_SUCCESS; rm_msg = 1'b1;
            hand_off_nxt = HO_DISTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
          end
        end else begin
          if (over) begin
            outcome = OUT_FAILURE; rm_msg = 1'b1;
            hand_off_nxt = HO_PROTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
          end else if (!it.fault_seen || it.backup_cleared) begin
            outcome = OUT_SUCCESS; rm_msg = 1'b1;
            hand_off_nxt = HO_PROTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
          end
        end
      end
      PH_BACKUP: begin
        if (over) begin
          if (it.open_permitted) begin
            open_cmd = 1'b1;
            active_limit_nxt = open_check_limit_r; elapsed_nxt = '0;
            phase_nxt = PH_BKDETECT;
          end
        end else begin
          // later checks override earlier ones
          if (!it.fault_seen) begin
            hand_off_nxt = HO_EXIT; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
          end
          if (it.neighbour_refused && it.open_permitted) begin
            open_cmd = 1'b1;
            active_limit_nxt = open_check_limit_r; elapsed_nxt = '0;
            hand_off_nxt = HO_NONE; hand_off_step_nxt = ST_NONE; phase_nxt = PH_BKDETECT;
          end
          if (it.backup_cleared) begin
            hand_off_nxt = HO_DISTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
          end
        end
      end
      PH_BKDETECT: begin
        if (over) begin
          rej = 1'b1; st_msg = 1'b1;
          hand_off_nxt = HO_PROTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
        end else if (!it.fault_seen) begin
          outcome = OUT_SUCCESS; rm_msg = 1'b1;
          hand_off_nxt = HO_DISTLOCK; hand_off_step_nxt = ST_NONE; phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        if (it.restart) begin
          phase_nxt = PH_START; hand_off_nxt = HO_NONE; hand_off_step_nxt = ST_NONE;
        end
      end
      default: ;
    endcase

    out_nxt.phase_now        = phase_nxt;
    out_nxt.running          = run_flag_nxt;
    out_nxt.open_command     = open_cmd;
    out_nxt.send_status      = st_msg;
    out_nxt.send_removal     = rm_msg;
    out_nxt.removal_outcome  = outcome;
    out_nxt.refused_open     = rej;
    out_nxt.snapshot_request = snap;
    out_nxt.exit_target      = hand_off_nxt;
    out_nxt.insulate_step    = hand_off_step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      sub_step_r      <= 1'b0;
      elapsed_r       <= '0;
      active_limit_r  <= '0;
      first_send_r    <= 1'b0;
      run_flag_r      <= 1'b0;
      hand_off_r      <= HO_NONE;
      hand_off_step_r <= ST_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r         <= phase_nxt;
        sub_step_r      <= sub_step_nxt;
        elapsed_r       <= elapsed_nxt;
        active_limit_r  <= active_limit_nxt;
        first_send_r    <= first_send_nxt;
        run_flag_r      <= run_flag_nxt;
        hand_off_r      <= hand_off_nxt;
        hand_off_step_r <= hand_off_step_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_r <= out_nxt;
  end

  // an accepted item always leaves a result waiting
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("no result after accepted item");

  // outside the done phase no hand-off target is held
  a_handoff_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DONE) |-> (hand_off_r == HO_NONE && hand_off_step_r == ST_NONE))
    else $error("hand-off target held outside done phase");

  // a removal message always carries an outcome, and only then
  a_removal_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.send_removal == (out_r.removal_outcome != OUT_NONE)))
    else $error("removal outcome without removal message");

  // the open command leads into an open-detect phase, or into done when a
  // backup clearance on the same tick overrides the neighbour refusal
  a_open_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.open_command) |->
      (out_r.phase_now == PH_CENTER || out_r.phase_now == PH_BKDETECT ||
       out_r.phase_now == PH_DONE))
    else $error("open command outside detect phases");

endmodule

### tb/sv/feeder_fault_removal_sequencer_top_tb.sv
// Self-checking bench for feeder_fault_removal_sequencer_top: a tick-level model of the
// phases, timer and hand-off predicts each report; directed, saturation and random runs.
// Depends on ffrs_pkg, ffrs_chan_if and the top level.
`timescale 1ns / 1ps

module feeder_fault_removal_sequencer_top_tb;
  import ffrs_pkg::*;

  // narrow tick counter so it can be driven to its top in a short run
  localparam int TIMER_W = 8;
  localparam int LIMIT_NS = 10_000_000;
  localparam cfg_index_t REG_UNMAPPED_LO = cfg_index_t'(4);
  localparam cfg_index_t REG_UNMAPPED_HI = cfg_index_t'(8'hFF);

  logic clk;
  logic rst_n;

  ffrs_chan_if #(.payload_t(in_item_t))  in_ch  ();
  ffrs_chan_if #(.payload_t(out_item_t)) out_ch ();
  ffrs_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  feeder_fault_removal_sequencer_top #(.TIMER_WIDTH(TIMER_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // switch model state
  phase_t               seq_phase      = PH_START;
  logic                 seq_sub        = 1'b0;
  logic [TIMER_W-1:0]   seq_elapsed    = '0;
  limit_t               seq_limit      = '0;
  logic                 seq_first_send = 1'b0;
  logic                 seq_run        = 1'b0;
  hand_off_t            seq_hand       = HO_NONE;
  step_t                seq_step       = ST_NONE;

  limit_t lim_gather      = GATHER_LIMIT_RST;
  limit_t lim_open_check  = OPEN_CHECK_LIMIT_RST;
  limit_t lim_backup_wait = BACKUP_WAIT_LIMIT_RST;
  limit_t lim_reject_wait = REJECT_WAIT_LIMIT_RST;

  out_item_t awaited_reports[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int ticks_sent      = 0;
  int reports_checked = 0;
  int limit_writes    = 0;
  int mismatches      = 0;
  logic [7:0] phases_seen = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic void rearm(limit_t lim);
    seq_limit   = lim;
    seq_elapsed = '0;
  endfunction

  function automatic void park(hand_off_t h, step_t s);
    seq_hand  = h;
    seq_step  = s;
    seq_phase = PH_DONE;
  endfunction

  // one timer tick of the sequencer; returns the report taken after the update
  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t r;
    logic over;
    r = '0;
    if (seq_elapsed != '1) seq_elapsed = seq_elapsed + 1'b1;
    over = (32'(seq_elapsed) >= 32'(seq_limit));
    case (seq_phase)
      PH_START: begin
        if (t.fault_seen) begin
          seq_run = 1'b1; r.send_status = 1'b1; r.snapshot_request = 1'b1;
          rearm(lim_gather); seq_sub = 1'b0; seq_phase = PH_GATHER;
        end else if (t.trigger_seen) begin
          seq_run = 1'b1; r.send_status = 1'b1;
          rearm(lim_gather); seq_first_send = 1'b1;
          seq_sub = 1'b0; seq_phase = PH_DELAY;
        end else if (t.reject_insulate) begin
          seq_run = 1'b1; park(HO_INSULATE, ST_BACKUP);
        end else if (t.transfer_permitted) begin
          seq_run = 1'b1; seq_sub = 1'b0; park(HO_TRANSFER, ST_NONE);
        end else if (t.income_loss_fault) begin
          seq_run = 1'b1; park(HO_INSULATE, ST_BACKUP);
        end
      end
      PH_GATHER: begin
        if (over) seq_phase = PH_TREAT;
      end
      PH_DELAY: begin
        if (!seq_sub) begin
          if (over) begin
            if (t.fault_seen) seq_phase = PH_TREAT;
            else seq_sub = 1'b1;
          end else if (t.fault_seen && seq_first_send) begin
            seq_first_send = 1'b0; r.send_status = 1'b1;
          end
        end else begin
          if (t.in_fault_area && t.on_tie_path) park(HO_INSULATE, ST_INIT);
          else if (t.on_tie_path) park(HO_INSULATE, ST_AREA);
          else park(HO_EXIT, ST_NONE);
        end
      end
      PH_TREAT: begin
        if (t.in_fault_area) begin
          if (t.open_permitted) begin
            r.open_command = 1'b1; rearm(lim_open_check);
            seq_sub = 1'b0; seq_phase = PH_CENTER;
          end
        end else begin
          rearm(lim_backup_wait); seq_phase = PH_BACKUP;
        end
      end
      PH_CENTER: begin
        if (!seq_sub) begin
          if (over) begin
            r.refused_open = 1'b1; r.send_status = 1'b1; seq_sub = 1'b1;
            rearm(lim_reject_wait);
          end else if (!t.fault_seen && t.open_position) begin
            r.removal_outcome = OUT_SUCCESS; r.send_removal = 1'b1;
            park(HO_DISTLOCK, ST_NONE);
          end
        end else begin
          if (over) begin
            r.removal_outcome = OUT_FAILURE; r.send_removal = 1'b1;
            park(HO_PROTLOCK, ST_NONE);
          end else if (!t.fault_seen || t.backup_cleared) begin
            r.removal_outcome = OUT_SUCCESS; r.send_removal = 1'b1;
            park(HO_PROTLOCK, ST_NONE);
          end
        end
      end
      PH_BACKUP: begin
        if (over) begin
          if (t.open_permitted) begin
            r.open_command = 1'b1; rearm(lim_open_check); seq_phase = PH_BKDETECT;
          end
        end else begin
          // later checks override earlier ones; the open pulse survives
          if (!t.fault_seen) park(HO_EXIT, ST_NONE);
          if (t.neighbour_refused && t.open_permitted) begin
            r.open_command = 1'b1; rearm(lim_open_check);
            seq_hand = HO_NONE; seq_step = ST_NONE; seq_phase = PH_BKDETECT;
          end
          if (t.backup_cleared) park(HO_DISTLOCK, ST_NONE);
        end
      end
      PH_BKDETECT: begin
        if (over) begin
          r.refused_open = 1'b1; r.send_status = 1'b1; park(HO_PROTLOCK, ST_NONE);
        end else if (!t.fault_seen) begin
          r.removal_outcome = OUT_SUCCESS; r.send_removal = 1'b1;
          park(HO_DISTLOCK, ST_NONE);
        end
      end
      default: begin
        if (t.restart) begin
          seq_phase = PH_START; seq_hand = HO_NONE; seq_step = ST_NONE;
        end
      end
    endcase
    r.phase_now     = seq_phase;
    r.running       = seq_run;
    r.exit_target   = seq_hand;
    r.insulate_step = seq_step;
    return r;
  endfunction

  task automatic check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // reports are checked before the tick accepted on the same edge is modeled
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (awaited_reports.size() == 0) begin
          $error("report with no tick outstanding");
          mismatches++;
        end else begin
          exp_r = awaited_reports.pop_front();
          reports_checked++;
          check_field("phase_now", exp_r.phase_now, got.phase_now);
          check_field("running", exp_r.running, got.running);
          check_field("open_command", exp_r.open_command, got.open_command);
          check_field("send_status", exp_r.send_status, got.send_status);
          check_field("send_removal", exp_r.send_removal, got.send_removal);
          check_field("removal_outcome", exp_r.removal_outcome, got.removal_outcome);
          check_field("refused_open", exp_r.refused_open, got.refused_open);
          check_field("snapshot_request", exp_r.snapshot_request, got.snapshot_request);
          check_field("exit_target", exp_r.exit_target, got.exit_target);
          check_field("insulate_step", exp_r.insulate_step, got.insulate_step);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_writes++;
        case (cfg_ch.payload.index)
          REG_GATHER_LIMIT:      lim_gather      = cfg_ch.payload.data;
          REG_OPEN_CHECK_LIMIT:  lim_open_check  = cfg_ch.payload.data;
          REG_BACKUP_WAIT_LIMIT: lim_backup_wait = cfg_ch.payload.data;
          REG_REJECT_WAIT_LIMIT: lim_reject_wait = cfg_ch.payload.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        exp_r = advance_sequencer(in_ch.payload);
        phases_seen[exp_r.phase_now] = 1'b1;
        awaited_reports.push_back(exp_r);
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(in_item_t t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(cfg_index_t idx, limit_t val);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_limits(limit_t g, limit_t o, limit_t b, limit_t r);
    write_limit(REG_GATHER_LIMIT, g);
    write_limit(REG_OPEN_CHECK_LIMIT, o);
    write_limit(REG_BACKUP_WAIT_LIMIT, b);
    write_limit(REG_REJECT_WAIT_LIMIT, r);
  endtask

  // random flags, steered by the modeled phase so sequences run to completion
  function automatic in_item_t shape_tick();
    in_item_t t;
    int pick;
    t = in_item_t'($urandom);
    if ($urandom_range(99) < 15) return t;
    case (seq_phase)
      PH_START: begin
        pick = $urandom_range(5);
        t.fault_seen         = (pick == 0);
        t.trigger_seen       = (pick == 1);
        t.reject_insulate    = (pick == 2);
        t.transfer_permitted = (pick == 3);
        t.income_loss_fault  = (pick == 4);
      end
      PH_CENTER: begin
        t.fault_seen     = ($urandom_range(3) != 0);
        t.backup_cleared = ($urandom_range(4) == 0);
      end
      PH_BACKUP: begin
        t.fault_seen        = ($urandom_range(6) != 0);
        t.neighbour_refused = ($urandom_range(6) == 0);
        t.backup_cleared    = ($urandom_range(9) == 0);
      end
      PH_BKDETECT: t.fault_seen = ($urandom_range(2) != 0);
      PH_DONE:     t.restart = ($urandom_range(9) < 4);
      default: ;
    endcase
    return t;
  endfunction

  task automatic test_directed();
    in_item_t t;
    send_idle_pct = 0;
    stall_pct     = 0;
    write_all_limits(limit_t'(2), limit_t'(2), limit_t'(2), limit_t'(1));
    write_limit(REG_UNMAPPED_LO, 16'hFFFF);
    write_limit(REG_UNMAPPED_HI, 16'h0000);
    t = '0; t.restart = 1'b1; send_tick(t);          // ignored outside done
    t = '0; t.fault_seen = 1'b1; send_tick(t);
    t = '0; send_tick(t);
    t = '0; send_tick(t);                             // gather expires
    t = '0; t.in_fault_area = 1'b1; send_tick(t);     // no permission: stays
    t.open_permitted = 1'b1; send_tick(t);
    t = '0; t.open_position = 1'b1; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    t = '0; t.trigger_seen = 1'b1; send_tick(t);
    t = '0; t.fault_seen = 1'b1; send_tick(t);        // first status resend
    t = '0; send_tick(t);
    t = '0; t.in_fault_area = 1'b1; t.on_tie_path = 1'b1; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    t = '0; t.fault_seen = 1'b1; send_tick(t);
    t = '0; send_tick(t);
    t = '0; send_tick(t);
    t = '0; t.fault_seen = 1'b1; send_tick(t);        // outside area: backup
    // all backup exits at once; last one wins, open still pulses
    t = '0; t.neighbour_refused = 1'b1; t.open_permitted = 1'b1;
    t.backup_cleared = 1'b1; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    t = '0; t.reject_insulate = 1'b1; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    t = '0; t.transfer_permitted = 1'b1; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    t = '0; t.income_loss_fault = 1'b1; send_tick(t);
    t = '1; send_tick(t);                             // done: restart
    drain_reports();
  endtask

  // park in backup with the widest wait so the tick counter pins at its top
  task automatic test_timer_saturation();
    in_item_t t;
    send_idle_pct = 0;
    stall_pct     = 0;
    write_all_limits(limit_t'(0), limit_t'(3), 16'hFFFF, limit_t'(3));
    t = '0; t.fault_seen = 1'b1; send_tick(t);
    t = '0; send_tick(t);
    t = '0; t.fault_seen = 1'b1; send_tick(t);
    t = '0; t.fault_seen = 1'b1;
    repeat ((1 << TIMER_W) + 4) send_tick(t);
    t.open_permitted = 1'b1; send_tick(t);
    t = '0; send_tick(t);
    t = '0; t.restart = 1'b1; send_tick(t);
    drain_reports();
  endtask

  task automatic test_random_traffic(int n, int s_pct, int r_pct,
                                     limit_t g, limit_t o, limit_t b, limit_t r);
    write_all_limits(g, o, b, r);
    send_idle_pct = s_pct;
    stall_pct     = r_pct;
    repeat (n) begin
      // plain stretches between bursts of idling
      if ($urandom_range(9) == 0) begin
        send_idle_pct = (send_idle_pct == 0) ? s_pct : 0;
        stall_pct     = (stall_pct == 0) ? r_pct : 0;
      end
      send_tick(shape_tick());
    end
    drain_reports();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_timer_saturation();
    test_random_traffic(140, 0, 0, limit_t'($urandom_range(5)), limit_t'($urandom_range(5)),
                        limit_t'($urandom_range(5)), limit_t'($urandom_range(5)));
    test_random_traffic(140, 83, 0, limit_t'($urandom_range(8)), limit_t'($urandom_range(8)),
                        limit_t'($urandom_range(8)), limit_t'($urandom_range(8)));
    test_random_traffic(140, 0, 83, limit_t'(0), limit_t'(0), limit_t'(0), limit_t'(0));
    test_random_traffic(140, 12, 12, limit_t'(1), 16'hFFFF, limit_t'(0), 16'hFFFF);

    if (awaited_reports.size() != 0) begin
      $error("%0d reports never arrived", awaited_reports.size());
      mismatches++;
    end
    $display("Sent %0d ticks over %0d register writes; %0d reports checked, %0d mismatches.",
             ticks_sent, limit_writes, reports_checked, mismatches);
    $display("Phases reached (bit per phase, done is MSB): %b", phases_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
